>>> rtl/pctbl_pkg.sv
package pctbl_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int CATS_DEF   = 4;
  localparam int NUM_BUDGET = 4;
  localparam int BK_AW      = 11;
  localparam int LVL_W      = 27;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_VAL  = 2'd2;
  localparam logic [1:0] KIND_POL  = 2'd3;

  localparam logic [2:0] ST_SPENT   = 3'd0;
  localparam logic [2:0] ST_UNLIM   = 3'd1;
  localparam logic [2:0] ST_BADCAT  = 3'd2;
  localparam logic [2:0] ST_LIMITED = 3'd3;
  localparam logic [2:0] ST_CAP     = 3'd4;
  localparam logic [2:0] ST_REJ     = 3'd5;
  localparam logic [2:0] ST_TICK    = 3'd6;

  localparam logic [2:0] CFG_MAX_NEW = 3'd4;

  localparam logic [LVL_W-1:0] TOKEN = LVL_W'(1000);

  typedef struct packed {
    logic [31:0] client;
    logic [31:0] last_seen;
    logic [31:0] acc;
    logic [31:0] lim;
    logic [31:0] rej;
  } slot_rec_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [31:0]      last;
  } bk_ent_t;

  typedef struct packed {
    logic             fill_we;
    logic [BK_AW-1:0] fill_addr;
    logic [LVL_W-1:0] fill_level;
    logic [31:0]      fill_last;
    logic             go;
    logic [BK_AW-1:0] addr;
    logic [31:0]      now;
    logic [15:0]      rate;
    logic [LVL_W-1:0] cap;
  } bk_req_t;

  typedef struct packed {
    logic done;
    logic spent;
  } bk_rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [LVL_W-1:0] cap_of(input logic [31:0] b);
    logic [15:0] base;
    base = (b[31:16] != 16'd0) ? b[31:16] : b[15:0];
    return LVL_W'(base) * TOKEN;
  endfunction

endpackage

>>> rtl/pctbl_bucket.sv
module pctbl_bucket #(
  parameter int SLOTS      = pctbl_pkg::SLOTS_DEF,
  parameter int CATEGORIES = pctbl_pkg::CATS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pctbl_pkg::bk_req_t bk_req_i,
  output pctbl_pkg::bk_rsp_t bk_rsp_o
);
  import pctbl_pkg::*;

  localparam int BDEPTH = SLOTS * CATEGORIES;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_RD    = 3'd1;
  localparam logic [2:0] B_MUL   = 3'd2;
  localparam logic [2:0] B_ADD   = 3'd3;
  localparam logic [2:0] B_SPEND = 3'd4;

  bk_ent_t bmem [BDEPTH];

  logic [2:0]       st_q, st_d;
  logic [BAW-1:0]   addr_q, addr_d;
  logic [31:0]      now_q, now_d;
  logic [15:0]      rate_q, rate_d;
  logic [LVL_W-1:0] cap_q, cap_d;
  bk_ent_t          ent_q;
  logic [47:0]      prod_q, prod_d;
  logic             adv_q, adv_d;
  logic [31:0]      nlast_q, nlast_d;
  logic [LVL_W-1:0] nl_q, nl_d;
  logic [48:0]      sum;
  logic             spent;
  logic [LVL_W-1:0] wlevel;

  assign sum    = 49'(ent_q.level) + 49'(prod_q);
  assign spent  = (nl_q >= TOKEN);
  assign wlevel = spent ? nl_q - TOKEN : nl_q;

  always_comb begin
    st_d    = st_q;
    addr_d  = addr_q;
    now_d   = now_q;
    rate_d  = rate_q;
    cap_d   = cap_q;
    prod_d  = prod_q;
    adv_d   = adv_q;
    nlast_d = nlast_q;
    nl_d    = nl_q;
    case (st_q)
      B_IDLE: begin
        if (bk_req_i.go) begin
          addr_d = bk_req_i.addr[BAW-1:0];
          now_d  = bk_req_i.now;
          rate_d = bk_req_i.rate;
          cap_d  = bk_req_i.cap;
          st_d   = B_RD;
        end
      end
      B_RD: st_d = B_MUL;
      B_MUL: begin
        adv_d   = (now_q > ent_q.last);
        prod_d  = adv_d ? (now_q - ent_q.last) * 48'(rate_q) : 48'd0;
        nlast_d = adv_d ? now_q : ent_q.last;
        st_d    = B_ADD;
      end
      B_ADD: begin
        if (adv_q) begin
          nl_d = (sum < 49'(cap_q)) ? sum[LVL_W-1:0] : cap_q;
        end else begin
          nl_d = ent_q.level;
        end
        st_d = B_SPEND;
      end
      B_SPEND: st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    now_q   <= now_d;
    rate_q  <= rate_d;
    cap_q   <= cap_d;
    prod_q  <= prod_d;
    adv_q   <= adv_d;
    nlast_q <= nlast_d;
    nl_q    <= nl_d;
  end

  always_ff @(posedge clk_i) begin
    if (bk_req_i.fill_we) begin
      bmem[bk_req_i.fill_addr[BAW-1:0]] <= '{level: bk_req_i.fill_level,
                                             last: bk_req_i.fill_last};
    end else if (st_q == B_SPEND) begin
      bmem[addr_q] <= '{level: wlevel, last: nlast_q};
    end
    if (st_q == B_RD) begin
      ent_q <= bmem[addr_q];
    end
  end

  assign bk_rsp_o.done  = (st_q == B_SPEND);
  assign bk_rsp_o.spent = spent;

endmodule

>>> rtl/per_client_token_bucket_limiter.sv
// Each command first scans the client table one slot per cycle through its single read port. A
// tick, a rejection or a bad category then completes; for a request, a new or fresh slot then
// fills its buckets one category per cycle, and the bucket refill runs through one shared
// multiplier and adder in four steps. busy stays high for the whole command. The result appears
// on the output ports for exactly one cycle with done_o and must be taken then, since the
// receiver cannot stall the block. Configuration is written through the cfg channel, which is
// always ready; the user must write it only while busy is low, as the block does not enforce it.
module per_client_token_bucket_limiter #(
  parameter int SLOTS      = pctbl_pkg::SLOTS_DEF,
  parameter int CATEGORIES = pctbl_pkg::CATS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [31:0] player_id_i,
  input  logic [2:0]  category_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] tick_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [2:0]  status_o,
  output logic        client_known_o,
  output logic [31:0] client_accepted_count_o,
  output logic [31:0] client_limited_count_o,
  output logic [31:0] client_rejected_count_o,
  output logic [31:0] category_limited_total_o,
  output logic [31:0] validator_total_o,
  output logic [31:0] policy_total_o,
  output logic [31:0] new_client_reject_total_o
);
  import pctbl_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_RATE   = 3'd4;
  localparam logic [2:0] S_WAITB  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  slot_rec_t slot_mem [SLOTS];
  slot_rec_t rd_rec_q;

  logic [2:0]        state_q, state_d;
  logic [SW:0]       cnt_q, cnt_d;
  logic              ev_vld_q, ev_vld_d;
  logic [SW-1:0]     ev_idx_q, ev_idx_d;
  logic              free_found_q, free_found_d;
  logic [SW-1:0]     free_idx_q, free_idx_d;
  logic [SW-1:0]     lru_idx_q, lru_idx_d;
  logic [31:0]       lru_last_q, lru_last_d;
  logic [1:0]        kind_q, kind_d;
  logic [31:0]       id_q, id_d;
  logic [2:0]        cat_q, cat_d;
  logic [31:0]       now_q, now_d;
  logic [31:0]       tick_q, tick_d;
  slot_rec_t         rec_q, rec_d;
  logic              known_q, known_d;
  logic [SW-1:0]     s_q, s_d;
  logic [2:0]        status_q, status_d;
  logic              acc_q, acc_d;
  logic              wr_slot_q, wr_slot_d;
  logic [31:0]       fill_last_q, fill_last_d;
  logic [CW-1:0]     fc_q, fc_d;
  logic [31:0]       budget_q [NUM_BUDGET];
  logic [31:0]       budget_d [NUM_BUDGET];
  logic [15:0]       max_new_q, max_new_d;
  logic [SLOTS-1:0]  fresh_q, fresh_d;
  logic [SLOTS-1:0]  vld_q, vld_d;
  logic [31:0]       lpc_q [CATEGORIES];
  logic [31:0]       lpc_d [CATEGORIES];
  logic [31:0]       val_cnt_q, val_cnt_d;
  logic [31:0]       pol_cnt_q, pol_cnt_d;
  logic [31:0]       cap_cnt_q, cap_cnt_d;
  logic [31:0]       last_tick_q, last_tick_d;
  logic [15:0]       ntt_q, ntt_d;

  slot_rec_t         eff_rec;
  logic [31:0]       cur_budget;
  logic [31:0]       fill_budget;
  logic              cat_ok;
  logic [SW-1:0]     new_s;
  bk_req_t           bk_req;
  bk_rsp_t           bk_rsp;

  function automatic logic [31:0] budget_of(input logic [2:0] c,
                                            input logic [31:0] b0,
                                            input logic [31:0] b1,
                                            input logic [31:0] b2,
                                            input logic [31:0] b3);
    logic [31:0] r;
    case (c)
      3'd0:    r = b0;
      3'd1:    r = b1;
      3'd2:    r = b2;
      3'd3:    r = b3;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  assign cat_ok      = (int'(cat_q) < CATEGORIES);
  assign cur_budget  = budget_of(cat_q, budget_q[0], budget_q[1], budget_q[2], budget_q[3]);
  assign fill_budget = budget_of(3'(fc_q), budget_q[0], budget_q[1], budget_q[2],
                                 budget_q[3]);
  assign eff_rec     = vld_q[ev_idx_q] ? rd_rec_q : '0;
  assign new_s       = free_found_q ? free_idx_q : lru_idx_q;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bk_req            = '0;
    bk_req.fill_we    = (state_q == S_FILL);
    bk_req.fill_addr  = BK_AW'(int'(s_q) * CATEGORIES + int'(fc_q));
    bk_req.fill_level = cap_of(fill_budget);
    bk_req.fill_last  = fill_last_q;
    bk_req.go         = (state_q == S_RATE) && (cur_budget[15:0] != 16'd0);
    bk_req.addr       = BK_AW'(int'(s_q) * CATEGORIES + int'(cat_q));
    bk_req.now        = now_q;
    bk_req.rate       = cur_budget[15:0];
    bk_req.cap        = cap_of(cur_budget);
  end

  pctbl_bucket #(
    .SLOTS      (SLOTS),
    .CATEGORIES (CATEGORIES)
  ) u_bucket (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bk_req_i (bk_req),
    .bk_rsp_o (bk_rsp)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ev_vld_d     = 1'b0;
    ev_idx_d     = ev_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    lru_idx_d    = lru_idx_q;
    lru_last_d   = lru_last_q;
    kind_d       = kind_q;
    id_d         = id_q;
    cat_d        = cat_q;
    now_d        = now_q;
    tick_d       = tick_q;
    rec_d        = rec_q;
    known_d      = known_q;
    s_d          = s_q;
    status_d     = status_q;
    acc_d        = acc_q;
    wr_slot_d    = wr_slot_q;
    fill_last_d  = fill_last_q;
    fc_d         = fc_q;
    budget_d     = budget_q;
    max_new_d    = max_new_q;
    fresh_d      = fresh_q;
    vld_d        = vld_q;
    lpc_d        = lpc_q;
    val_cnt_d    = val_cnt_q;
    pol_cnt_d    = pol_cnt_q;
    cap_cnt_d    = cap_cnt_q;
    last_tick_d  = last_tick_q;
    ntt_d        = ntt_q;

    if (cfg_valid_i && cfg_ready_o) begin
      if (int'(cfg_index_i) < NUM_BUDGET) begin
        budget_d[cfg_index_i[1:0]] = cfg_data_i;
      end else if (cfg_index_i == CFG_MAX_NEW) begin
        max_new_d = cfg_data_i[15:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d       = kind_i;
          id_d         = player_id_i;
          cat_d        = category_i;
          now_d        = now_ms_i;
          tick_d       = tick_i;
          rec_d        = '0;
          known_d      = 1'b0;
          free_found_d = 1'b0;
          acc_d        = 1'b0;
          wr_slot_d    = 1'b0;
          cnt_d        = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (int'(cnt_q) < SLOTS) begin
          ev_vld_d = 1'b1;
          ev_idx_d = cnt_q[SW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (!known_q && eff_rec.client == id_q) begin
            known_d = 1'b1;
            s_d     = ev_idx_q;
            rec_d   = eff_rec;
          end
          if (!free_found_q && eff_rec.client == 32'd0) begin
            free_found_d = 1'b1;
            free_idx_d   = ev_idx_q;
          end
          if (ev_idx_q == '0 || eff_rec.last_seen < lru_last_q) begin
            lru_idx_d  = ev_idx_q;
            lru_last_d = eff_rec.last_seen;
          end
        end else if (int'(cnt_q) >= SLOTS) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        case (kind_q)
          KIND_TICK: begin
            if (tick_q != last_tick_q) begin
              last_tick_d = tick_q;
              ntt_d       = '0;
            end
            status_d = ST_TICK;
          end
          KIND_VAL, KIND_POL: begin
            if (kind_q == KIND_VAL) begin
              val_cnt_d = sat_inc(val_cnt_q);
            end else begin
              pol_cnt_d = sat_inc(pol_cnt_q);
            end
            if (known_q) begin
              rec_d.rej = sat_inc(rec_q.rej);
              wr_slot_d = 1'b1;
            end
            status_d = ST_REJ;
          end
          default: begin
            if (!cat_ok) begin
              acc_d    = 1'b1;
              status_d = ST_BADCAT;
            end else if (known_q) begin
              rec_d.last_seen = now_q;
              wr_slot_d       = 1'b1;
              fc_d            = '0;
              fill_last_d     = 32'd0;
              if (fresh_q[s_q]) begin
                fresh_d[s_q] = 1'b0;
                state_d      = S_FILL;
              end else begin
                state_d = S_RATE;
              end
            end else if (max_new_q != 16'd0 && ntt_q >= max_new_q) begin
              cap_cnt_d = sat_inc(cap_cnt_q);
              status_d  = ST_CAP;
            end else begin
              if (ntt_q != 16'hFFFF) begin
                ntt_d = ntt_q + 16'd1;
              end
              s_d            = new_s;
              rec_d          = '0;
              rec_d.client   = id_q;
              rec_d.last_seen = now_q;
              known_d        = 1'b1;
              wr_slot_d      = 1'b1;
              fresh_d[new_s] = 1'b0;
              fc_d           = '0;
              fill_last_d    = now_q;
              state_d        = S_FILL;
            end
          end
        endcase
      end
      S_FILL: begin
        fc_d = fc_q + 1'b1;
        if (int'(fc_q) == CATEGORIES - 1) begin
          state_d = S_RATE;
        end
      end
      S_RATE: begin
        if (cur_budget[15:0] == 16'd0) begin
          rec_d.acc = sat_inc(rec_q.acc);
          acc_d     = 1'b1;
          status_d  = ST_UNLIM;
          state_d   = S_DONE;
        end else begin
          state_d = S_WAITB;
        end
      end
      S_WAITB: begin
        if (bk_rsp.done) begin
          if (bk_rsp.spent) begin
            rec_d.acc = sat_inc(rec_q.acc);
            acc_d     = 1'b1;
            status_d  = ST_SPENT;
          end else begin
            rec_d.lim               = sat_inc(rec_q.lim);
            lpc_d[cat_q[CW-1:0]]    = sat_inc(lpc_q[cat_q[CW-1:0]]);
            status_d                = ST_LIMITED;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (wr_slot_q) begin
          vld_d[s_q] = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ev_vld_q    <= 1'b0;
      budget_q    <= '{default: '0};
      max_new_q   <= '0;
      fresh_q     <= '1;
      vld_q       <= '0;
      lpc_q       <= '{default: '0};
      val_cnt_q   <= '0;
      pol_cnt_q   <= '0;
      cap_cnt_q   <= '0;
      last_tick_q <= '0;
      ntt_q       <= '0;
    end else begin
      state_q     <= state_d;
      ev_vld_q    <= ev_vld_d;
      budget_q    <= budget_d;
      max_new_q   <= max_new_d;
      fresh_q     <= fresh_d;
      vld_q       <= vld_d;
      lpc_q       <= lpc_d;
      val_cnt_q   <= val_cnt_d;
      pol_cnt_q   <= pol_cnt_d;
      cap_cnt_q   <= cap_cnt_d;
      last_tick_q <= last_tick_d;
      ntt_q       <= ntt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    ev_idx_q     <= ev_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    lru_idx_q    <= lru_idx_d;
    lru_last_q   <= lru_last_d;
    kind_q       <= kind_d;
    id_q         <= id_d;
    cat_q        <= cat_d;
    now_q        <= now_d;
    tick_q       <= tick_d;
    rec_q        <= rec_d;
    known_q      <= known_d;
    s_q          <= s_d;
    status_q     <= status_d;
    acc_q        <= acc_d;
    wr_slot_q    <= wr_slot_d;
    fill_last_q  <= fill_last_d;
    fc_q         <= fc_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && wr_slot_q) begin
      slot_mem[s_q] <= rec_q;
    end
    rd_rec_q <= slot_mem[cnt_q[SW-1:0]];
  end

  assign done_o                    = (state_q == S_DONE);
  assign accepted_o                = acc_q;
  assign status_o                  = status_q;
  assign client_known_o            = known_q;
  assign client_accepted_count_o   = known_q ? rec_q.acc : 32'd0;
  assign client_limited_count_o    = known_q ? rec_q.lim : 32'd0;
  assign client_rejected_count_o   = known_q ? rec_q.rej : 32'd0;
  assign category_limited_total_o  = cat_ok ? lpc_q[cat_q[CW-1:0]] : 32'd0;
  assign validator_total_o         = val_cnt_q;
  assign policy_total_o            = pol_cnt_q;
  assign new_client_reject_total_o = cap_cnt_q;

endmodule

>>> rtl/pctbl_checker.sv
module pctbl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        accepted_o,
  input logic [2:0]  status_o,
  input logic        client_known_o,
  input logic [31:0] client_accepted_count_o
);
  import pctbl_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !done_o)
    else $error("result beat outside a command or repeated");

  a_acc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && accepted_o |->
      (status_o == ST_SPENT || status_o == ST_UNLIM || status_o == ST_BADCAT))
    else $error("admitted beat with a refusing status");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !client_known_o |-> client_accepted_count_o == 32'd0)
    else $error("unknown client reports a nonzero count");

endmodule

bind per_client_token_bucket_limiter pctbl_checker u_pctbl_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .start                   (start),
  .busy                    (busy),
  .done_o                  (done_o),
  .accepted_o              (accepted_o),
  .status_o                (status_o),
  .client_known_o          (client_known_o),
  .client_accepted_count_o (client_accepted_count_o)
);
